// File: src/ctp_pkg.sv
`timescale 1ns / 1ps

package ctp_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int POS_WIDTH  = 32;
	localparam int FRAC_BITS  = 24;

	// normalized time s lies in [0, 2^FRAC_BITS]
	localparam int S_WIDTH     = FRAC_BITS + 1;
	localparam int REM_WIDTH   = TIME_WIDTH + 1;
	localparam int BLEND_WIDTH = S_WIDTH + 2;
	localparam int MAG_WIDTH   = POS_WIDTH + 1;
	localparam int PROD_WIDTH  = MAG_WIDTH + S_WIDTH;

	localparam logic [S_WIDTH-1:0] BLEND_ONE = S_WIDTH'(1) << FRAC_BITS;

	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = (TIME_WIDTH > POS_WIDTH) ? TIME_WIDTH : POS_WIDTH;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_START_TIME = 2'd0,
		REG_END_TIME   = 2'd1,
		REG_START_POS  = 2'd2,
		REG_END_POS    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_MOVING = 2'd1,
		PH_AFTER  = 2'd2
	} phase_t;

	typedef struct packed {
		logic   vld;
		phase_t phase;
	} ctp_tag_t;

endpackage

// File: src/ctp_divider.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: quo = floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per stage, MSB first.
module ctp_divider
	import ctp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  ctp_tag_t              in_tag,
	input  logic [TIME_WIDTH-1:0] num,
	input  logic [TIME_WIDTH-1:0] den,
	output ctp_tag_t              out_tag,
	output logic [S_WIDTH-1:0]    quo
);

	ctp_tag_t               tag_sd [S_WIDTH];
	logic [REM_WIDTH-1:0]   rem_sd [S_WIDTH];
	logic [S_WIDTH-1:0]     quo_sd [S_WIDTH];

	for (genvar k = 0; k < S_WIDTH; k++) begin : g_step
		logic [REM_WIDTH-1:0] x;
		ctp_tag_t             tag_in;
		logic [S_WIDTH-1:0]   quo_in;
		logic                 ge;

		if (k == 0) begin : g_head
			assign x      = {1'b0, num};
			assign tag_in = in_tag;
			assign quo_in = '0;
		end else begin : g_body
			assign x      = {rem_sd[k-1][REM_WIDTH-2:0], 1'b0};
			assign tag_in = tag_sd[k-1];
			assign quo_in = quo_sd[k-1];
		end

		assign ge = (x >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_sd[k] <= '0;
			end else if (en) begin
				tag_sd[k] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k] <= ge ? (x - {1'b0, den}) : x;
				quo_sd[k] <= {quo_in[S_WIDTH-2:0], ge};
			end
		end
	end

	assign out_tag = tag_sd[S_WIDTH-1];
	assign quo     = quo_sd[S_WIDTH-1];

endmodule

// File: src/cubic_trajectory_point.sv
`timescale 1ns / 1ps

// Cubic point-to-point move with zero velocity at both ends.
// Config: write start_time, end_time, start_position, end_position through
//   cfg_we / cfg_idx / cfg_wdata while no result is outstanding.
// Input channel (in_valid / in_ready / time_now): one tick per transfer.
// Output channel (out_valid / out_ready / position / phase): one result per
//   input, in order. phase: 0 before start or empty window, 1 moving, 2 done.
// Pipeline: a result reaches out_valid through one capture stage, one stage
//   per bit of the 25-bit quotient in the divider, four multiply / blend
//   stages and one output register.
// Throughput: one transfer per cycle while in_ready is high, set by the fully pipelined divider.
// Reset: arst_n clears the config registers to 0 and empties the pipeline.
// Stall: a two-entry output buffer (output register plus skid entry) takes
//   one more result while out_ready is low, after which in_ready drops and
//   the whole pipeline freezes. Nothing is dropped or repeated.
module cubic_trajectory_point
	import ctp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [TIME_WIDTH-1:0]     time_now,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [POS_WIDTH-1:0] position,
	output logic [1:0]                phase
);

	// ---------------- configuration ----------------
	logic [TIME_WIDTH-1:0]       start_time_q, end_time_q;
	logic signed [POS_WIDTH-1:0] start_pos_q, end_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			end_time_q   <= '0;
			start_pos_q  <= '0;
			end_pos_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_START_TIME: start_time_q <= cfg_wdata[TIME_WIDTH-1:0];
				REG_END_TIME:   end_time_q   <= cfg_wdata[TIME_WIDTH-1:0];
				REG_START_POS:  start_pos_q  <= $signed(cfg_wdata[POS_WIDTH-1:0]);
				REG_END_POS:    end_pos_q    <= $signed(cfg_wdata[POS_WIDTH-1:0]);
				default: ;
			endcase
		end
	end

	// Values derived from config only, registered from the config registers;
	// ready when an item classified after a write reaches the stages that read them.
	logic signed [MAG_WIDTH-1:0] pos_diff;
	logic [TIME_WIDTH-1:0]       den_q;
	logic [MAG_WIDTH-1:0]        mag_q;
	logic                        neg_q;

	assign pos_diff = MAG_WIDTH'(end_pos_q) - MAG_WIDTH'(start_pos_q);

	always_ff @(posedge clk) begin
		den_q <= end_time_q - start_time_q;
		neg_q <= pos_diff[MAG_WIDTH-1];
		mag_q <= pos_diff[MAG_WIDTH-1] ? $unsigned(-pos_diff) : $unsigned(pos_diff);
	end

	// ---------------- flow control ----------------
	logic out_v_q, skid_v_q;
	logic en;

	// pipeline advances unless the skid entry is occupied
	assign en       = !skid_v_q;
	assign in_ready = en;

	// ---------------- stage 1: classify ----------------
	phase_t                in_phase;
	ctp_tag_t              tag_s1;
	logic [TIME_WIDTH-1:0] num_s1;

	always_comb begin
		if (end_time_q == start_time_q || time_now < start_time_q) begin
			in_phase = PH_BEFORE;
		end else if (time_now > end_time_q) begin
			in_phase = PH_AFTER;
		end else begin
			in_phase = PH_MOVING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.vld   <= in_valid;
			tag_s1.phase <= in_phase;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= time_now - start_time_q;
		end
	end

	// ---------------- divider: s = elapsed * 2^F / window ----------------
	ctp_tag_t           tag_dv;
	logic [S_WIDTH-1:0] quo_dv;

	ctp_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (tag_s1),
		.num     (num_s1),
		.den     (den_q),
		.out_tag (tag_dv),
		.quo     (quo_dv)
	);

	// ---------------- stage 2: s^2 ----------------
	logic [2*S_WIDTH-1:0] sq_full;
	ctp_tag_t             tag_s2;
	logic [S_WIDTH-1:0]   s_s2, sq_s2;
	logic                 full_s2;

	assign sq_full = quo_dv * quo_dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= quo_dv;
			sq_s2   <= sq_full[FRAC_BITS +: S_WIDTH];
			full_s2 <= quo_dv[FRAC_BITS];
		end
	end

	// ---------------- stage 3: s^3 ----------------
	logic [2*S_WIDTH-1:0] cube_full;
	ctp_tag_t             tag_s3;
	logic [S_WIDTH-1:0]   sq_s3, cube_s3;
	logic                 full_s3;

	assign cube_full = sq_s2 * s_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= sq_s2;
			cube_s3 <= cube_full[FRAC_BITS +: S_WIDTH];
			full_s3 <= full_s2;
		end
	end

	// ---------------- stage 4: blend = 3 s^2 - 2 s^3, clamped ----------------
	logic [BLEND_WIDTH-1:0] blend_raw;
	ctp_tag_t               tag_s4;
	logic [S_WIDTH-1:0]     blend_s4;

	assign blend_raw = {2'b00, sq_s3} + {1'b0, sq_s3, 1'b0} - {1'b0, cube_s3, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else if (en) begin
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (full_s3 || blend_raw > {2'b00, BLEND_ONE}) begin
				blend_s4 <= BLEND_ONE;
			end else begin
				blend_s4 <= blend_raw[S_WIDTH-1:0];
			end
		end
	end

	// ---------------- stage 5: |diff| * blend ----------------
	logic [PROD_WIDTH-1:0] prod_full;
	ctp_tag_t              tag_s5;
	logic [POS_WIDTH-1:0]  prod_s5;
	logic                  frac_nz_s5;

	assign prod_full = mag_q * blend_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else if (en) begin
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5    <= prod_full[FRAC_BITS +: POS_WIDTH];
			frac_nz_s5 <= |prod_full[FRAC_BITS-1:0];
		end
	end

	// ---------------- result select ----------------
	// Negative moves round the magnitude up so the step floors toward -inf.
	logic [POS_WIDTH-1:0]        step_up;
	logic signed [POS_WIDTH-1:0] res_pos;

	assign step_up = prod_s5 + POS_WIDTH'(frac_nz_s5);

	always_comb begin
		case (tag_s5.phase)
			PH_BEFORE: res_pos = start_pos_q;
			PH_AFTER:  res_pos = end_pos_q;
			PH_MOVING: begin
				if (neg_q) begin
					res_pos = start_pos_q - $signed(step_up);
				end else begin
					res_pos = start_pos_q + $signed(prod_s5);
				end
			end
			default:   res_pos = start_pos_q;
		endcase
	end

	// ---------------- output register + skid entry ----------------
	logic                        incoming;
	logic signed [POS_WIDTH-1:0] out_pos_q, skid_pos_q;
	phase_t                      out_ph_q, skid_ph_q;

	assign incoming = en && tag_s5.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (incoming) begin
			if (!out_v_q || out_ready) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_pos_q <= skid_pos_q;
				out_ph_q  <= skid_ph_q;
			end
		end else if (incoming) begin
			if (!out_v_q || out_ready) begin
				out_pos_q <= res_pos;
				out_ph_q  <= tag_s5.phase;
			end else begin
				skid_pos_q <= res_pos;
				skid_ph_q  <= tag_s5.phase;
			end
		end
	end

	assign out_valid = out_v_q;
	assign position  = out_pos_q;
	assign phase     = out_ph_q;

endmodule

// File: src/ctp_checker.sv
`timescale 1ns / 1ps

module ctp_checker
	import ctp_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [POS_WIDTH-1:0] position,
	input logic [1:0]                 phase
);

	// reset empties the output buffer
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> (!out_valid && in_ready))
		else $error("output buffer not empty during reset");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(position) && $stable(phase)))
		else $error("result changed while stalled");

	// input backpressure only follows an output stall
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("in_ready low without an output stall");

endmodule

bind cubic_trajectory_point ctp_checker u_ctp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.position  (position),
	.phase     (phase)
);

// File: dv/trajectory_checker.sv
`timescale 1ns / 1ps

module trajectory_checker
	import ctp_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]    cfg_idx,
	input  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [TIME_WIDTH-1:0]       time_now,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic signed [POS_WIDTH-1:0] position,
	input  logic [1:0]                  phase,
	output int                          errors,
	output int                          pending
);

	typedef struct {
		logic signed [POS_WIDTH-1:0] pos;
		phase_t                      ph;
	} point_t;

	logic [TIME_WIDTH-1:0]       move_t0, move_t1;
	logic signed [POS_WIDTH-1:0] move_p0, move_p1;
	point_t                      due_points[$];

	task automatic flag_error(input string what);
		$display("%0t ns  MISMATCH  %s", $realtime, what);
		errors = errors + 1;
	endtask

	function automatic point_t cubic_point(input logic [TIME_WIDTH-1:0] t);
		point_t      r;
		logic [63:0] num, den, s, s2, s3, blend;
		longint      dlt, bl, acc;
		r.pos = move_p0;
		r.ph  = PH_BEFORE;
		if (move_t1 == move_t0 || t < move_t0) begin
			return r;
		end
		if (t > move_t1) begin
			r.pos = move_p1;
			r.ph  = PH_AFTER;
			return r;
		end
		num = 64'(t) - 64'(move_t0);
		den = 64'(move_t1) - 64'(move_t0);
		s   = (num << FRAC_BITS) / den;
		if (s >= (64'd1 << FRAC_BITS)) begin
			blend = 64'd1 << FRAC_BITS;
		end else begin
			s2    = (s * s) >> FRAC_BITS;
			s3    = (s2 * s) >> FRAC_BITS;
			blend = 3 * s2 - 2 * s3;
			if (blend > (64'd1 << FRAC_BITS))
				blend = 64'd1 << FRAC_BITS;
		end
		// signed product, arithmetic shift floors toward minus infinity
		dlt   = longint'(move_p1) - longint'(move_p0);
		bl    = blend;
		acc   = longint'(move_p0) + ((dlt * bl) >>> FRAC_BITS);
		r.pos = acc[POS_WIDTH-1:0];
		r.ph  = PH_MOVING;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		point_t want;
		if (!arst_n) begin
			move_t0 = '0;
			move_t1 = '0;
			move_p0 = '0;
			move_p1 = '0;
			due_points.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_START_TIME: move_t0 = cfg_wdata[TIME_WIDTH-1:0];
					REG_END_TIME:   move_t1 = cfg_wdata[TIME_WIDTH-1:0];
					REG_START_POS:  move_p0 = cfg_wdata[POS_WIDTH-1:0];
					REG_END_POS:    move_p1 = cfg_wdata[POS_WIDTH-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_points.size() == 0) begin
					flag_error($sformatf("unexpected point position=%0d phase=%0d",
						position, phase));
				end else begin
					want = due_points.pop_front();
					if (position !== want.pos)
						flag_error($sformatf("position %0d, want %0d", position, want.pos));
					if (phase !== want.ph)
						flag_error($sformatf("phase %0d, want %0d", phase, want.ph));
				end
			end
			if (in_valid && in_ready)
				due_points.push_back(cubic_point(time_now));
			pending <= due_points.size();
		end
	end

endmodule

// File: dv/cubic_trajectory_point_test.sv
`timescale 1ns / 1ps

module cubic_trajectory_point_test;
	import ctp_pkg::*;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	cfg_reg_t                    cfg_idx;
	logic [CFG_DATA_WIDTH-1:0]   cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic [TIME_WIDTH-1:0]       time_now;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [POS_WIDTH-1:0] position;
	logic [1:0]                  phase;

	int fails;
	int pending;

	// idle controls, read by the sender task and the receiver process
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int hold_len = 0;

	// current move window, used to aim ticks at the interesting region
	logic [TIME_WIDTH-1:0] mv_t0 = '0, mv_t1 = '0;
	logic [TIME_WIDTH-1:0] ticks[$];

	cubic_trajectory_point dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_now  (time_now),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.position  (position),
		.phase     (phase)
	);

	trajectory_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_now  (time_now),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.position  (position),
		.phase     (phase),
		.errors    (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("cubic_trajectory_point_test: errors");
		$finish;
	end

	// Writes all four move registers back to back; we stays high across them.
	task automatic load_move(input logic [TIME_WIDTH-1:0] t0, t1,
			input logic signed [POS_WIDTH-1:0] p0, p1);
		mv_t0 = t0;
		mv_t1 = t1;
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_START_TIME;
		cfg_wdata <= t0;
		@(posedge clk);
		cfg_idx   <= REG_END_TIME;
		cfg_wdata <= t1;
		@(posedge clk);
		cfg_idx   <= REG_START_POS;
		cfg_wdata <= p0;
		@(posedge clk);
		cfg_idx   <= REG_END_POS;
		cfg_wdata <= p1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One tick transfer. Valid stays up after acceptance so back-to-back
	// transfers never lower and raise it within one step; an idle gap drops it.
	task automatic send_tick(input logic [TIME_WIDTH-1:0] t);
		if (tx_idle) begin
			while ($urandom_range(0, 99) < 24) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		time_now <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_queued();
		foreach (ticks[i])
			send_tick(ticks[i]);
		ticks.delete();
	endtask

	// Drop valid and wait for every outstanding point; the extra step makes
	// sure the count already reflects the last transfer. Then cover latency.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Mostly inside the window, some right on its edges, the rest anywhere.
	function automatic logic [TIME_WIDTH-1:0] pick_tick();
		logic [TIME_WIDTH-1:0] span;
		int unsigned           r;
		span = mv_t1 - mv_t0;
		r    = $urandom_range(0, 99);
		if (mv_t1 > mv_t0 && r < 70)
			return mv_t0 + TIME_WIDTH'($urandom_range(span));
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0:       return mv_t0 - 1;
				1:       return mv_t0;
				2:       return mv_t1;
				default: return mv_t1 + 1;
			endcase
		end
		return $urandom;
	endfunction

	// Receiver: random back-pressure while rx_idle is set, else always ready, or one long hold-off when asked.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				out_ready <= rx_idle ? ($urandom_range(0, 99) >= 24) : 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int                          ph, k;
		logic [TIME_WIDTH-1:0]       t0, t1;
		logic signed [POS_WIDTH-1:0] p0, p1;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_START_TIME;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		time_now  <= '0;
		out_ready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// registers still at reset: empty window, start position held
		ticks = '{32'h0000_0000, 32'hFFFF_FFFF};
		send_queued();
		settle();

		// plain window: before, on start, inside, on end, past end
		load_move(32'd1000, 32'd2000, -32'sd5000000, 32'sd7000000);
		ticks = '{32'd0, 32'd999, 32'd1000, 32'd1001, 32'd1500, 32'd1999,
			32'd2000, 32'd2001, 32'hFFFF_FFFF};
		send_queued();
		settle();

		// widest window and full position swing
		load_move(32'h0000_0000, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		ticks = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
			32'hFFFF_FFFF};
		send_queued();
		settle();

		// reversed window: nothing is inside, only before / after apply
		load_move(32'd500, 32'd100, 32'sd123, -32'sd456);
		ticks = '{32'd50, 32'd100, 32'd300, 32'd500, 32'd600};
		send_queued();
		settle();

		// --- random, one move setting per pass ---
		for (ph = 0; ph < 9; ph++) begin
			tx_idle = 1'b1;
			rx_idle = 1'b1;
			p0 = $urandom;
			p1 = $urandom;
			case (ph)
				0: begin
					// full range, falling move
					t0 = 32'h0000_0000;
					t1 = 32'hFFFF_FFFF;
					p0 = 32'sh7FFF_FFFF;
					p1 = 32'sh8000_0000;
				end
				1: begin
					// one-tick window
					t0 = $urandom_range(1000);
					t1 = t0 + 1;
					p0 = 32'sh7FFF_FFFF;
					p1 = 32'sh8000_0000;
				end
				2: begin
					t0 = $urandom_range(32'hFFFF_FF00);
					t1 = t0 + 3;
				end
				3: begin
					t0 = $urandom;
					t1 = t0 + $urandom_range(32'h0010_0000, 1);
				end
				4: begin
					// window against the top of the tick range, no travel
					t0 = 32'hFFFF_F000;
					t1 = 32'hFFFF_FFFF;
					p1 = p0;
				end
				5: begin
					t0 = $urandom;
					t1 = $urandom;
				end
				6: begin
					t1 = $urandom_range(100000);
					t0 = t1 + 1 + $urandom_range(1000);
				end
				7: begin
					t0 = $urandom_range(32'h0010_0000);
					t1 = t0 + $urandom_range(32'h0FFF_FFFF, 32'h0100_0000);
				end
				default: begin
					// empty window somewhere random
					t0 = $urandom;
					t1 = t0;
				end
			endcase
			load_move(t0, t1, p0, p1);
			if (ph == 3) begin
				// receiver stalls long while ticks keep coming: pipeline fills
				tx_idle  = 1'b0;
				hold_len = 120;
			end
			if (ph == 5) begin
				// long stretch with no idling on either side
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			for (k = 0; k < 62; k++)
				send_tick(pick_tick());
			settle();
		end

		if (fails == 0 && pending == 0)
			$display("cubic_trajectory_point_test: clean");
		else
			$display("cubic_trajectory_point_test: errors");
		$finish;
	end

endmodule
